// ===== rtl/core/string_to_unsigned_parser_top_assert.svh =====
// Assertion macros for the string-to-unsigned parser RTL.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef STRING_TO_UNSIGNED_PARSER_TOP_ASSERT_SVH
`define STRING_TO_UNSIGNED_PARSER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define S2U_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next
`define S2U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/s2u_pkg.sv =====
// Shared types, constants and character helpers for the string-to-unsigned parser.
// No dependencies; used by every other file of the block but the assertion header.
package s2u_pkg;

    // Widths and defaults
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int INDEX_WIDTH_DEF = 16;
    localparam int END_INDEX_WIDTH = 16;
    localparam int RADIX_WIDTH     = 6;
    localparam int CHAR_WIDTH      = 8;
    localparam int DIGIT_WIDTH     = 6;

    // Digit code meaning "not a digit in any base"
    localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT = '1;

    // Bases
    localparam logic [RADIX_WIDTH-1:0] BASE_AUTO = 6'd0;
    localparam logic [RADIX_WIDTH-1:0] BASE_MIN  = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] BASE_OCT  = 6'd8;
    localparam logic [RADIX_WIDTH-1:0] BASE_DEC  = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] BASE_HEX  = 6'd16;
    localparam logic [RADIX_WIDTH-1:0] BASE_MAX  = 6'd36;

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_A    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_Z    = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_X    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_X    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_OFFS = 8'd55;   // 'A' - 10
    localparam logic [CHAR_WIDTH-1:0] CH_LO_OFFS = 8'd87;   // 'a' - 10

    // Parse phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_HEXPF,
        PH_DIGIT
    } phase_t;

    // One input beat
    typedef struct packed {
        logic                   start_req;
        logic [RADIX_WIDTH-1:0] radix;
        logic [CHAR_WIDTH-1:0]  char_code;
    } item_t;

    // Status fields of one result
    typedef struct packed {
        logic                       success;
        logic [END_INDEX_WIDTH-1:0] end_index;
    } res_ctl_t;

    // Digit value of a character, NO_DIGIT if it is not 0-9, a-z or A-Z
    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [DIGIT_WIDTH-1:0] d;
        d = NO_DIGIT;
        if (c inside {[CH_ZERO:CH_NINE]})
            d = DIGIT_WIDTH'(c - CH_ZERO);
        else if (c inside {[CH_UP_A:CH_UP_Z]})
            d = DIGIT_WIDTH'(c - CH_UP_OFFS);
        else if (c inside {[CH_LO_A:CH_LO_Z]})
            d = DIGIT_WIDTH'(c - CH_LO_OFFS);
        return d;
    endfunction

    // White space: tab to carriage return, and blank
    function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

// ===== rtl/core/s2u_in_if.sv =====
// Input channel interface of the string-to-unsigned parser: valid/ready plus one character.
// Depends on s2u_pkg for the field widths.
interface s2u_in_if;

    logic                           valid;
    logic                           ready;
    logic                           start_req;
    logic [s2u_pkg::RADIX_WIDTH-1:0] radix;
    logic [s2u_pkg::CHAR_WIDTH-1:0]  char_code;

    modport source (output valid, output start_req, output radix, output char_code,
                    input ready);
    modport sink   (input valid, input start_req, input radix, input char_code,
                    output ready);

endinterface

// ===== rtl/core/s2u_out_if.sv =====
// Result channel interface of the string-to-unsigned parser: valid/ready plus one result.
// Depends on s2u_pkg for widths and the default value width.
interface s2u_out_if #(
    parameter int VALUE_WIDTH = s2u_pkg::VALUE_WIDTH_DEF
);

    logic                                valid;
    logic                                ready;
    logic [VALUE_WIDTH-1:0]              value;
    logic                                success;
    logic [s2u_pkg::END_INDEX_WIDTH-1:0] end_index;

    modport source (output valid, output value, output success, output end_index,
                    input ready);
    modport sink   (input valid, input value, input success, input end_index,
                    output ready);

endinterface

// ===== rtl/core/string_to_unsigned_parser_top.sv =====
// Streaming string-to-unsigned parser (strtoul-like), one character beat per cycle.
// in_ch: beats carry start_req, radix (sampled on start, 0 = automatic) and char_code.
// out_ch: one result beat per parsed number: value, success, end_index.
// A beat with start_req restarts the parse; beats while idle without start are dropped.
// The first character that is not a digit of the active base (NUL included) ends the
// number and produces exactly one result; the parser then idles until the next start.
// Path: a character is registered at acceptance and worked through the parse logic
// from the input register; a result it causes is loaded into the output register,
// which drives out_ch.valid, as soon as that register is free.
// Throughput: one character per cycle unless a result waits for the output register,
// set by the digit step (a VALUE_WIDTH by 6 bit multiply-add and overflow check).
// Stall: a finished result waits in the output register while further characters keep
// flowing; only a character that would produce a second result stops, and in_ch.ready
// drops once the input register is held behind it.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to idle.
// Depends on s2u_pkg, s2u_in_if, s2u_out_if, s2u_in_reg, s2u_parse and s2u_out_reg.
module string_to_unsigned_parser_top #(
    parameter int VALUE_WIDTH = s2u_pkg::VALUE_WIDTH_DEF,
    parameter int INDEX_WIDTH = s2u_pkg::INDEX_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    s2u_in_if.sink    in_ch,
    s2u_out_if.source out_ch
);

    logic                   item_valid;
    s2u_pkg::item_t         item;
    logic                   take;
    logic                   emit;
    logic                   out_free;
    logic [VALUE_WIDTH-1:0] res_value;
    s2u_pkg::res_ctl_t      res_ctl;

    // Input register
    s2u_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parse state and step logic
    s2u_parse #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .emit       (emit),
        .res_value  (res_value),
        .res_ctl    (res_ctl)
    );

    // Result register
    s2u_out_reg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && emit),
        .res_value (res_value),
        .res_ctl   (res_ctl),
        .out_free  (out_free),
        .out_ch    (out_ch)
    );

endmodule

// ===== rtl/core/s2u_in_reg.sv =====
// Input register of the parser: holds one accepted character beat.
// Depends on s2u_pkg and s2u_in_if.
module s2u_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    s2u_in_if.sink           in_ch,
    input  logic             take,
    output logic             item_valid,
    output s2u_pkg::item_t   item
);

    logic           valid_reg;
    logic           valid_next;
    s2u_pkg::item_t item_reg;
    logic           load;

    // Free when empty or when the held beat moves on this cycle
    assign in_ch.ready = !valid_reg || take;
    assign load        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.start_req <= in_ch.start_req;
            item_reg.radix     <= in_ch.radix;
            item_reg.char_code <= in_ch.char_code;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/s2u_parse.sv =====
// Parse state and single-pass next-state logic: one character per cycle unless a result stalls.
// Depends on s2u_pkg and the assertion macro header.
`include "string_to_unsigned_parser_top_assert.svh"

module s2u_parse #(
    parameter int VALUE_WIDTH = s2u_pkg::VALUE_WIDTH_DEF,
    parameter int INDEX_WIDTH = s2u_pkg::INDEX_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  s2u_pkg::item_t         item,
    input  logic                   out_free,
    output logic                   take,
    output logic                   emit,
    output logic [VALUE_WIDTH-1:0] res_value,
    output s2u_pkg::res_ctl_t      res_ctl
);

    localparam int PROD_WIDTH = VALUE_WIDTH + s2u_pkg::RADIX_WIDTH + 1;
    localparam logic [INDEX_WIDTH-1:0] POS_MAX = '1;

    // State
    s2u_pkg::phase_t                  phase_reg,  phase_next;
    logic [s2u_pkg::RADIX_WIDTH-1:0]  base_reg,   base_next;
    logic [VALUE_WIDTH-1:0]           acc_reg,    acc_next;
    logic                             neg_reg,    neg_next;
    logic                             seen_reg,   seen_next;
    logic                             ovf_reg,    ovf_next;
    logic [INDEX_WIDTH-1:0]           pos_reg,    pos_next;

    // Working values
    s2u_pkg::phase_t                  ph_v;
    logic [s2u_pkg::RADIX_WIDTH-1:0]  base_v;
    logic [VALUE_WIDTH-1:0]           acc_v;
    logic                             neg_v;
    logic                             seen_v;
    logic                             ovf_v;
    logic [INDEX_WIDTH-1:0]           pos_v;
    logic [INDEX_WIDTH-1:0]           idx_v;
    logic                             skip_v;
    logic                             do_first;
    logic                             do_take;
    logic [s2u_pkg::DIGIT_WIDTH-1:0]  dig;
    logic [PROD_WIDTH-1:0]            prod;
    logic [s2u_pkg::CHAR_WIDTH-1:0]   c;

    assign c   = item.char_code;
    assign dig = s2u_pkg::digit_of(c);

    // Next state and result for the held character
    always_comb
    begin
        ph_v     = phase_reg;
        base_v   = base_reg;
        acc_v    = acc_reg;
        neg_v    = neg_reg;
        seen_v   = seen_reg;
        ovf_v    = ovf_reg;
        pos_v    = pos_reg;
        skip_v   = 1'b0;
        do_first = 1'b0;
        do_take  = 1'b0;
        emit     = 1'b0;
        idx_v    = '0;
        prod     = '0;

        // Restart, ignore, or advance the position counter
        if (item.start_req)
        begin
            base_v = item.radix;
            acc_v  = '0;
            neg_v  = 1'b0;
            seen_v = 1'b0;
            ovf_v  = 1'b0;
            pos_v  = '0;
            ph_v   = s2u_pkg::PH_SPACE;
        end
        else if (phase_reg == s2u_pkg::PH_IDLE)
        begin
            skip_v = 1'b1;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_v = pos_reg + 1'b1;
        end

        if (!skip_v)
        begin
            case (ph_v)
                s2u_pkg::PH_SPACE:
                begin
                    if (s2u_pkg::is_space(c))
                        ph_v = s2u_pkg::PH_SPACE;
                    else if (c == s2u_pkg::CH_MINUS)
                    begin
                        neg_v = 1'b1;
                        ph_v  = s2u_pkg::PH_SIGN;
                    end
                    else if (c == s2u_pkg::CH_PLUS)
                        ph_v = s2u_pkg::PH_SIGN;
                    else
                        do_first = 1'b1;
                end
                s2u_pkg::PH_SIGN:
                    do_first = 1'b1;
                s2u_pkg::PH_ZERO:
                begin
                    if (c == s2u_pkg::CH_LO_X || c == s2u_pkg::CH_UP_X)
                    begin
                        base_v = s2u_pkg::BASE_HEX;
                        ph_v   = s2u_pkg::PH_HEXPF;
                    end
                    else
                    begin
                        if (base_v == s2u_pkg::BASE_AUTO)
                            base_v = s2u_pkg::BASE_OCT;
                        do_take = 1'b1;
                    end
                end
                s2u_pkg::PH_HEXPF:
                begin
                    // A bare prefix ends at the 'x': the '0' was the number
                    if (dig < s2u_pkg::DIGIT_WIDTH'(s2u_pkg::BASE_HEX))
                        do_take = 1'b1;
                    else
                    begin
                        emit  = 1'b1;
                        idx_v = (pos_v == POS_MAX) ? pos_v : pos_v - 1'b1;
                    end
                end
                s2u_pkg::PH_DIGIT:
                    do_take = 1'b1;
                default:
                    ph_v = s2u_pkg::PH_IDLE;
            endcase
        end

        // First character after blanks and sign
        if (do_first)
        begin
            if (c == s2u_pkg::CH_ZERO &&
                (base_v == s2u_pkg::BASE_AUTO || base_v == s2u_pkg::BASE_HEX))
            begin
                acc_v  = '0;
                seen_v = 1'b1;
                ph_v   = s2u_pkg::PH_ZERO;
            end
            else
            begin
                if (base_v == s2u_pkg::BASE_AUTO)
                    base_v = s2u_pkg::BASE_DEC;
                do_take = 1'b1;
            end
        end

        // Digit in the active base, or end of the number
        if (do_take)
        begin
            // acc * base + digit, overflow when it leaves VALUE_WIDTH bits
            prod = PROD_WIDTH'(acc_v) * PROD_WIDTH'(base_v) + PROD_WIDTH'(dig);
            if (base_v < s2u_pkg::BASE_MIN || base_v > s2u_pkg::BASE_MAX ||
                dig >= s2u_pkg::DIGIT_WIDTH'(base_v))
            begin
                emit  = 1'b1;
                idx_v = seen_v ? pos_v : '0;
            end
            else
            begin
                if (!ovf_v)
                begin
                    if (prod[PROD_WIDTH-1:VALUE_WIDTH] != '0)
                        ovf_v = 1'b1;
                    else
                        acc_v = prod[VALUE_WIDTH-1:0];
                end
                seen_v = 1'b1;
                ph_v   = s2u_pkg::PH_DIGIT;
            end
        end

        if (emit)
            ph_v = s2u_pkg::PH_IDLE;

        phase_next = ph_v;
        base_next  = base_v;
        acc_next   = acc_v;
        neg_next   = neg_v;
        seen_next  = seen_v;
        ovf_next   = ovf_v;
        pos_next   = pos_v;
    end

    // Result fields
    always_comb
    begin
        if (ovf_v)
            res_value = '1;
        else if (neg_v)
            res_value = '0 - acc_v;
        else
            res_value = acc_v;
        res_ctl.success   = !ovf_v;
        res_ctl.end_index = s2u_pkg::END_INDEX_WIDTH'(idx_v);
    end

    // Move on unless a result has nowhere to go
    assign take = item_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= s2u_pkg::PH_IDLE;
            base_reg  <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
        end
    end

    // Checks
    `S2U_ASSERT_NEXT(a_idle_after_result, take && emit, phase_reg == s2u_pkg::PH_IDLE, "parser not idle after a result")
    `S2U_ASSERT_ALWAYS(a_idle_ignores, (item_valid && !item.start_req && phase_reg == s2u_pkg::PH_IDLE) -> !emit, "result from an ignored beat")
    `S2U_ASSERT_NEXT(a_pos_monotonic, take && !item.start_req, pos_reg >= $past(pos_reg), "position counter went backwards")
    `S2U_ASSERT_ALWAYS(a_ovf_fail, (item_valid && emit) -> (res_ctl.success == !ovf_v), "success disagrees with overflow")

endmodule

// ===== rtl/core/s2u_out_reg.sv =====
// Result register of the parser: holds one result beat until the sink takes it.
// Depends on s2u_pkg and s2u_out_if.
module s2u_out_reg #(
    parameter int VALUE_WIDTH = s2u_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [VALUE_WIDTH-1:0] res_value,
    input  s2u_pkg::res_ctl_t      res_ctl,
    output logic                   out_free,
    s2u_out_if.source              out_ch
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    s2u_pkg::res_ctl_t      ctl_reg;

    // Slot can take a new result when empty or drained this cycle
    assign out_free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= res_value;
            ctl_reg   <= res_ctl;
        end
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.value     = value_reg;
    assign out_ch.success   = ctl_reg.success;
    assign out_ch.end_index = ctl_reg.end_index;

endmodule

// ===== bench/number_check_pkg.sv =====
// Scoreboard for the string-to-unsigned parser bench: a bit-exact parse predictor
// and the queue of numbers it expects. Depends on s2u_pkg for widths and char codes.
`timescale 1ns / 1ps

package number_check_pkg;

    import s2u_pkg::*;

    localparam int VALUE_W = VALUE_WIDTH_DEF;
    localparam int INDEX_W = END_INDEX_WIDTH;
    localparam logic [INDEX_W-1:0] POS_MAX = '1;
    localparam int NOT_A_DIGIT = 64;

    // One expected result
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               success;
        logic [INDEX_W-1:0] end_index;
    } parsed_number_t;

    class number_tracker;

        // Predictor state
        phase_t                 ph;
        logic [RADIX_WIDTH-1:0] base;
        logic [VALUE_W-1:0]     acc;
        bit                     neg;
        bit                     seen;
        bit                     ovf;
        logic [INDEX_W-1:0]     pos;

        parsed_number_t expected_numbers[$];
        int errors;
        int checked;
        int dropped;

        function new();
            ph      = PH_IDLE;
            base    = '0;
            acc     = '0;
            neg     = 0;
            seen    = 0;
            ovf     = 0;
            pos     = '0;
            errors  = 0;
            checked = 0;
            dropped = 0;
        endfunction

        function int outstanding();
            return expected_numbers.size();
        endfunction

        // Digit value of a character in any base up to 36
        function int char_digit(logic [CHAR_WIDTH-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return int'(c - CH_ZERO);
            if (c >= CH_UP_A && c <= CH_UP_Z)
                return int'(c - CH_UP_A) + 10;
            if (c >= CH_LO_A && c <= CH_LO_Z)
                return int'(c - CH_LO_A) + 10;
            return NOT_A_DIGIT;
        endfunction

        // Close the number and queue what the block should report
        function void finish_number(logic [INDEX_W-1:0] idx);
            parsed_number_t num;
            if (ovf)
                num.value = '1;
            else if (neg)
                num.value = -acc;
            else
                num.value = acc;
            num.success   = !ovf;
            num.end_index = idx;
            expected_numbers.push_back(num);
            ph = PH_IDLE;
        endfunction

        // Accumulate a digit of the active base, or end the number
        function void take_digit(logic [CHAR_WIDTH-1:0] c);
            int                 d;
            logic [VALUE_W+5:0] wide;
            d = char_digit(c);
            if (base < BASE_MIN || base > BASE_MAX || d >= int'(base)) begin
                finish_number(seen ? pos : '0);
                return;
            end
            if (!ovf) begin
                wide = (VALUE_W+6)'(acc) * (VALUE_W+6)'(base) + (VALUE_W+6)'(d);
                if (wide[VALUE_W+5:VALUE_W] != 0)
                    ovf = 1;
                else
                    acc = wide[VALUE_W-1:0];
            end
            seen = 1;
            ph   = PH_DIGIT;
        endfunction

        // First character after blanks and sign: a leading zero may open a prefix
        function void first_char(logic [CHAR_WIDTH-1:0] c);
            if (c == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
                acc  = '0;
                seen = 1;
                ph   = PH_ZERO;
            end else begin
                if (base == BASE_AUTO)
                    base = BASE_DEC;
                take_digit(c);
            end
        endfunction

        // Accepted input beat
        function void note_char(logic start, logic [RADIX_WIDTH-1:0] rdx,
                                logic [CHAR_WIDTH-1:0] c);
            if (start) begin
                base = rdx;
                acc  = '0;
                neg  = 0;
                seen = 0;
                ovf  = 0;
                pos  = '0;
                ph   = PH_SPACE;
            end else if (ph == PH_IDLE) begin
                dropped++;
                return;
            end else if (pos != POS_MAX) begin
                pos++;
            end

            case (ph)
                PH_SPACE: begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                        // still in leading blanks
                    end else if (c == CH_MINUS) begin
                        neg = 1;
                        ph  = PH_SIGN;
                    end else if (c == CH_PLUS) begin
                        ph = PH_SIGN;
                    end else begin
                        first_char(c);
                    end
                end
                PH_SIGN:
                    first_char(c);
                PH_ZERO: begin
                    if (c == CH_LO_X || c == CH_UP_X) begin
                        base = BASE_HEX;
                        ph   = PH_HEXPF;
                    end else begin
                        if (base == BASE_AUTO)
                            base = BASE_OCT;
                        take_digit(c);
                    end
                end
                PH_HEXPF: begin
                    // bare prefix: the subject was just the zero
                    if (char_digit(c) < 16)
                        take_digit(c);
                    else
                        finish_number(pos == POS_MAX ? pos : pos - 1'b1);
                end
                default:
                    take_digit(c);
            endcase
        endfunction

        // Accepted result beat against the oldest expectation
        function void check_number(logic [VALUE_W-1:0] value, logic success,
                                   logic [INDEX_W-1:0] end_index);
            parsed_number_t want;
            if (expected_numbers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value %h success %b end_index %0d",
                         $time, value, success, end_index);
                return;
            end
            want = expected_numbers.pop_front();
            checked++;
            if (value !== want.value) begin
                errors++;
                $display("%0t: value mismatch, expected %h, got %h",
                         $time, want.value, value);
            end
            if (success !== want.success) begin
                errors++;
                $display("%0t: success mismatch, expected %b, got %b",
                         $time, want.success, success);
            end
            if (end_index !== want.end_index) begin
                errors++;
                $display("%0t: end_index mismatch, expected %0d, got %0d",
                         $time, want.end_index, end_index);
            end
        endfunction

    endclass

endpackage

// ===== bench/tb.sv =====
// Top-level bench for string_to_unsigned_parser_top: drives character strings with
// random gaps and result stalls, and checks results. Depends on s2u_pkg, the channel
// interfaces and number_check_pkg.
`timescale 1ns / 1ps

module tb;

    import s2u_pkg::*;
    import number_check_pkg::*;

    localparam int ITEM_TARGET   = 1600;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    logic clk;
    logic rst_n;

    s2u_in_if  in_ch ();
    s2u_out_if out_ch ();

    string_to_unsigned_parser_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    number_tracker tracker = new();

    logic [CHAR_WIDTH-1:0] line_buf[$];
    bit  gaps_on;
    bit  hold_results;
    int  hold_left;
    int  run_left;
    int  stall_left;
    int  cycle_count;
    int  beats_sent;
    int  random_beats;

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Monitor: results first, so a beat accepted now cannot cover for one
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready)
                tracker.check_number(out_ch.value, out_ch.success, out_ch.end_index);
            if (in_ch.valid && in_ch.ready)
                tracker.note_char(in_ch.start_req, in_ch.radix, in_ch.char_code);
        end
    end

    // Mostly short idle stretches, a few long ones
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Result side: ready bursts and stalls, plus the long hold-off on request
    always @(negedge clk)
    begin
        if (hold_results) begin
            hold_left    = HOLD_CYCLES;
            hold_results = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (run_left != 0) begin
            run_left--;
            out_ch.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            run_left   = $urandom_range(0, 30);
            stall_left = idle_length();
            out_ch.ready <= 1'b1;
        end
    end

    task automatic idle_gap();
        int n;
        n = gaps_on ? idle_length() : 0;
        if (n != 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // One character beat, held until accepted
    task automatic send_char(input logic start, input logic [RADIX_WIDTH-1:0] rdx,
                             input logic [CHAR_WIDTH-1:0] c);
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.start_req <= start;
        in_ch.radix     <= rdx;
        in_ch.char_code <= c;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        beats_sent++;
        idle_gap();
    endtask

    // Send line_buf as one string; radix on later beats is don't-care, so randomise it
    task automatic send_line(input logic [RADIX_WIDTH-1:0] rdx);
        foreach (line_buf[i])
            send_char(i == 0, (i == 0) ? rdx : RADIX_WIDTH'($urandom_range(0, 63)),
                      line_buf[i]);
    endtask

    task automatic send_text(input logic [RADIX_WIDTH-1:0] rdx, input string s,
                             input logic [CHAR_WIDTH-1:0] term);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        line_buf.push_back(term);
        send_line(rdx);
    endtask

    // Stop offering beats, then wait until every expected result has come
    task automatic wait_all_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed number with random content: blanks, sign, prefix, digits, terminator; some radices are invalid
    task automatic queue_number();
        logic [RADIX_WIDTH-1:0] rdx;
        int                     eff;
        int                     n;
        int                     v;
        line_buf.delete();
        case ($urandom_range(0, 9))
            0, 1, 2: rdx = BASE_AUTO;
            3:       rdx = BASE_HEX;
            4:       rdx = BASE_DEC;
            5:       rdx = BASE_OCT;
            6:       rdx = BASE_MIN;
            7:       rdx = RADIX_WIDTH'($urandom_range(2, 36));
            8:       rdx = BASE_MAX;
            default: rdx = $urandom_range(0, 3) == 0 ? RADIX_WIDTH'(1)
                                                     : RADIX_WIDTH'($urandom_range(37, 63));
        endcase
        eff = int'(rdx);

        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                line_buf.push_back($urandom_range(0, 5) == 0
                                   ? CH_SPACE : CH_TAB + CHAR_WIDTH'($urandom_range(0, 4)));
        case ($urandom_range(0, 3))
            0:       line_buf.push_back(CH_PLUS);
            1:       line_buf.push_back(CH_MINUS);
            default: ;
        endcase

        if ((rdx == BASE_AUTO || rdx == BASE_HEX) && $urandom_range(0, 2) == 0) begin
            line_buf.push_back(CH_ZERO);
            line_buf.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            eff = 16;
        end else if (rdx == BASE_AUTO) begin
            eff = 10;
            if ($urandom_range(0, 3) == 0) begin
                line_buf.push_back(CH_ZERO);
                eff = 8;
            end
        end
        if (eff < 2 || eff > 36)
            eff = 10;

        // long runs can reach overflow in every base
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 70) : $urandom_range(0, 6);
        repeat (n) begin
            v = ($urandom_range(0, 3) == 0) ? eff - 1 : $urandom_range(0, eff - 1);
            if (v < 10)
                line_buf.push_back(CH_ZERO + CHAR_WIDTH'(v));
            else
                line_buf.push_back(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A)
                                   + CHAR_WIDTH'(v - 10));
        end

        // terminator; now and then none, so the next start cuts the parse short
        case ($urandom_range(0, 14))
            0:                   ;
            1, 2, 3, 4, 5:       line_buf.push_back(8'h00);
            6, 7, 8:             line_buf.push_back(8'h2E);     // '.'
            9:                   line_buf.push_back(CH_SPACE);
            default:             line_buf.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
        endcase
        if (line_buf.size() == 0)
            line_buf.push_back(8'h00);
        send_line(rdx);
    endtask

    // Broken string: random radix and random bytes
    task automatic queue_noise();
        line_buf.delete();
        repeat ($urandom_range(1, 6))
            line_buf.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
        send_line(RADIX_WIDTH'($urandom_range(0, 63)));
    endtask

    initial
    begin
        bit held;
        bit paused;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.start_req = 1'b0;
        in_ch.radix     = '0;
        in_ch.char_code = '0;
        out_ch.ready    = 1'b0;
        gaps_on         = 1'b1;
        held            = 0;
        paused          = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle drop, blanks/plus/upper prefix/NUL, minus/octal/high byte,
        // largest radix with both letter cases, bare prefix, invalid radices
        send_char(1'b0, BASE_AUTO, CH_UP_A);
        send_text(BASE_AUTO, " +0X1f", 8'h00);
        send_text(BASE_AUTO, "-017", 8'hFF);
        send_text(BASE_MAX, "Zz", 8'h2E);
        send_text(BASE_AUTO, "0x", 8'h67);                // 'g' after the prefix
        send_text(RADIX_WIDTH'(1), "", CH_ZERO + 8'd1);
        send_text(RADIX_WIDTH'(63), "-", CH_SPACE);       // lone sign then blank
        wait_all_results();

        // Random strings
        while (random_beats < ITEM_TARGET) begin
            if (!held && random_beats >= 500) begin
                // keep sending while results are held off so the input stalls
                hold_results = 1;
                held         = 1;
            end
            if (!paused && random_beats >= 1000) begin
                wait_all_results();
                paused = 1;
            end
            gaps_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0)
                queue_noise();
            else
                queue_number();
            random_beats += line_buf.size();
            // stray characters, dropped unless a parse is still open
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2))
                    send_char(1'b0, RADIX_WIDTH'($urandom_range(0, 63)),
                              CHAR_WIDTH'($urandom_range(0, 255)));
        end

        wait_all_results();

        $display("Parsed %0d numbers from %0d character beats (%0d dropped while idle),",
                 tracker.checked, beats_sent, tracker.dropped);
        $display("over all radices and bad ones, with result hold-off and a full drain.");
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== string_to_unsigned_parser_top.f =====
+incdir+rtl/core
rtl/core/s2u_pkg.sv
rtl/core/s2u_in_if.sv
rtl/core/s2u_out_if.sv
rtl/core/s2u_in_reg.sv
rtl/core/s2u_parse.sv
rtl/core/s2u_out_reg.sv
rtl/core/string_to_unsigned_parser_top.sv
bench/number_check_pkg.sv
bench/tb.sv
